// File: sv/audio_peak_hold_meter_core_assert.svh
// Assertion macros shared by the peak meter modules.
// Every use expects signals named clk and rst_n in the enclosing module.
`ifndef AUDIO_PEAK_HOLD_METER_CORE_ASSERT_SVH
`define AUDIO_PEAK_HOLD_METER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define APHM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define APHM_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define APHM_ASSERT(label, prop, msg)
`define APHM_NEVER(label, cond, msg)
`endif

`endif

// File: sv/aphm_pkg.sv
package aphm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_PERIOD  = 8192;

    localparam int LEVEL_W = SAMPLE_BITS;
    localparam int COUNT_W = $clog2(MAX_PERIOD + 1);
    localparam int HOLD_W  = 24;
    localparam int FALL_W  = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(72000);
    localparam logic [FALL_W-1:0] FALL_RESET = FALL_W'(65335);

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_FACTOR  = 1'b1;

    // action codes of an input item
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_of_period;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] max_level;
        logic [LEVEL_W-1:0] peak_level;
    } out_item_t;

    typedef enum logic {
        CMD_PERIOD,
        CMD_READ
    } cmd_kind_t;

    // work handed from the front end to the level update
    typedef struct packed {
        cmd_kind_t          kind;
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_samples;
        logic [FALL_W-1:0] fall_factor;
    } cfg_t;

endpackage

// File: sv/aphm_front.sv
module aphm_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  aphm_pkg::in_item_t item,
    output logic            full,
    output logic            cmd_push,
    output aphm_pkg::cmd_t  cmd,
    input  logic            cmd_full
);

    logic [aphm_pkg::LEVEL_W-1:0] period_max_reg;
    logic [aphm_pkg::LEVEL_W-1:0] period_max_next;
    logic [aphm_pkg::COUNT_W-1:0] period_count_reg;
    logic [aphm_pkg::COUNT_W-1:0] period_count_next;

    logic [aphm_pkg::LEVEL_W-1:0] raw;
    logic [aphm_pkg::LEVEL_W-1:0] abs_value;
    logic [aphm_pkg::LEVEL_W-1:0] new_max;
    logic [aphm_pkg::COUNT_W-1:0] new_count;
    logic                         accept;
    logic                         is_read;

    assign full    = cmd_full;
    assign accept  = push & ~cmd_full;
    assign is_read = (item.action == aphm_pkg::ACT_READ);

    always_comb
    begin
        raw = item.sample;
        // negating the most negative sample yields 2^(N-1) read as unsigned
        abs_value = raw[aphm_pkg::LEVEL_W-1] ? (~raw + aphm_pkg::LEVEL_W'(1)) : raw;
        new_max   = (abs_value > period_max_reg) ? abs_value : period_max_reg;
        if (period_count_reg < aphm_pkg::COUNT_W'(aphm_pkg::MAX_PERIOD))
        begin
            new_count = period_count_reg + aphm_pkg::COUNT_W'(1);
        end
        else
        begin
            new_count = period_count_reg;
        end

        cmd_push   = accept & (is_read | item.last_of_period);
        cmd.kind   = is_read ? aphm_pkg::CMD_READ : aphm_pkg::CMD_PERIOD;
        cmd.level  = new_max;
        cmd.count  = new_count;

        period_max_next   = period_max_reg;
        period_count_next = period_count_reg;
        if (accept && !is_read)
        begin
            if (item.last_of_period)
            begin
                period_max_next   = '0;
                period_count_next = '0;
            end
            else
            begin
                period_max_next   = new_max;
                period_count_next = new_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_max_reg   <= '0;
            period_count_reg <= '0;
        end
        else
        begin
            period_max_reg   <= period_max_next;
            period_count_reg <= period_count_next;
        end
    end

endmodule

// File: sv/aphm_cmd_fifo.sv
`include "audio_peak_hold_meter_core_assert.svh"

module aphm_cmd_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aphm_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output aphm_pkg::cmd_t pop_data,
    output logic           empty
);

    aphm_pkg::cmd_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `APHM_NEVER(a_cmd_overflow, push && full, "command queue written while full")
    `APHM_NEVER(a_cmd_underflow, pop && empty, "command queue read while empty")
    `APHM_NEVER(a_cmd_count, cnt_reg > 2'd2, "command queue count out of range")

endmodule

// File: sv/aphm_back.sv
`include "audio_peak_hold_meter_core_assert.svh"

module aphm_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  aphm_pkg::cfg_t     cfg,
    input  logic               cmd_empty,
    input  aphm_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    output logic               empty,
    input  logic               pop,
    output aphm_pkg::out_item_t result
);

    localparam int PROD_W = aphm_pkg::LEVEL_W + aphm_pkg::FALL_W;

    logic [aphm_pkg::LEVEL_W-1:0] held_max_reg;
    logic [aphm_pkg::LEVEL_W-1:0] held_max_next;
    logic [aphm_pkg::LEVEL_W-1:0] peak_value_reg;
    logic [aphm_pkg::LEVEL_W-1:0] peak_value_next;
    logic [aphm_pkg::HOLD_W-1:0]  hold_left_reg;
    logic [aphm_pkg::HOLD_W-1:0]  hold_left_next;
    logic                         read_pending_reg;
    logic                         read_pending_next;

    aphm_pkg::out_item_t res_mem_reg [2];
    logic                res_wr_ptr_reg;
    logic                res_rd_ptr_reg;
    logic [1:0]          res_cnt_reg;
    logic [1:0]          res_cnt_next;
    logic                res_full;
    logic                res_push;

    logic [PROD_W-1:0]            prod;
    logic [aphm_pkg::HOLD_W-1:0]  count_ext;
    logic                         is_read;

    assign res_full = (res_cnt_reg == 2'd2);
    assign empty    = (res_cnt_reg == 2'd0);
    assign result   = res_mem_reg[res_rd_ptr_reg];
    assign is_read  = (cmd.kind == aphm_pkg::CMD_READ);

    // a read stalls only when the result queue has no room
    assign cmd_pop  = ~cmd_empty & (~is_read | ~res_full);
    assign res_push = cmd_pop & is_read;

    always_comb
    begin
        prod      = PROD_W'(peak_value_reg) * PROD_W'(cfg.fall_factor);
        count_ext = aphm_pkg::HOLD_W'(cmd.count);

        held_max_next     = held_max_reg;
        peak_value_next   = peak_value_reg;
        hold_left_next    = hold_left_reg;
        read_pending_next = read_pending_reg;

        if (cmd_pop)
        begin
            case (cmd.kind)
                aphm_pkg::CMD_READ:
                begin
                    read_pending_next = 1'b1;
                end
                aphm_pkg::CMD_PERIOD:
                begin
                    if (read_pending_reg)
                    begin
                        held_max_next     = cmd.level;
                        read_pending_next = 1'b0;
                    end
                    else if (cmd.level > held_max_reg)
                    begin
                        held_max_next = cmd.level;
                    end

                    if (cmd.level >= peak_value_reg)
                    begin
                        peak_value_next = cmd.level;
                        hold_left_next  = cfg.hold_samples;
                    end
                    else if (hold_left_reg != '0)
                    begin
                        hold_left_next = (hold_left_reg > count_ext) ?
                                         (hold_left_reg - count_ext) : '0;
                    end
                    else
                    begin
                        // Q0.16 decay, truncated
                        peak_value_next = prod[PROD_W-1:aphm_pkg::FALL_W];
                    end
                end
                default:
                begin
                    read_pending_next = read_pending_reg;
                end
            endcase
        end

        res_cnt_next = res_cnt_reg + {1'b0, res_push} - {1'b0, pop & ~empty};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_max_reg     <= '0;
            peak_value_reg   <= '0;
            hold_left_reg    <= '0;
            read_pending_reg <= 1'b0;
            res_wr_ptr_reg   <= 1'b0;
            res_rd_ptr_reg   <= 1'b0;
            res_cnt_reg      <= 2'd0;
        end
        else
        begin
            held_max_reg     <= held_max_next;
            peak_value_reg   <= peak_value_next;
            hold_left_reg    <= hold_left_next;
            read_pending_reg <= read_pending_next;
            res_cnt_reg      <= res_cnt_next;
            if (res_push)
            begin
                res_wr_ptr_reg <= ~res_wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                res_rd_ptr_reg <= ~res_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_ptr_reg] <= '{max_level: held_max_reg,
                                            peak_level: peak_value_reg};
        end
    end

    `APHM_NEVER(a_res_overflow, res_push && res_full, "result queue written while full")
    `APHM_ASSERT(a_read_arms, cmd_pop && is_read |=> read_pending_reg,
                 "read transaction did not arm the restart")
    `APHM_ASSERT(a_hold_keeps_peak,
                 cmd_pop && !is_read && cmd.level < peak_value_reg && hold_left_reg != '0
                 |=> $stable(peak_value_reg),
                 "peak changed while hold still running")
    `APHM_ASSERT(a_peak_no_rise_on_fall,
                 cmd_pop && !is_read && cmd.level < peak_value_reg
                 |=> peak_value_reg <= $past(peak_value_reg),
                 "peak rose without a louder period")

endmodule

// File: sv/audio_peak_hold_meter_core.sv
// Peak meter: signed samples come in through the input queue port, one transaction per
// clock while full is low, grouped into periods by last_of_period. A read item
// (action = 1) returns the max-since-read level and the held/decaying peak as it stands
// after every earlier completed period, and arms a restart of the max level at the next
// period end. Samples and reads are taken one per cycle unless full; a read's result
// reaches the result queue via the command queue. A two-entry command queue sits
// between the per-period accumulator and the level update, and the level update feeds
// a two-entry result queue, so full rises only when results are left unpopped and both
// queues fill up. Configuration writes are always ready: index 0 is hold_samples
// (reset 72000), index 1 is fall_factor (Q0.16, low 16 bits of the data, reset 65335).
module audio_peak_hold_meter_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  aphm_pkg::in_item_t                   item,
    output logic                                 full,
    output logic                                 empty,
    input  logic                                 pop,
    output aphm_pkg::out_item_t                  result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [aphm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aphm_pkg::CFG_W-1:0]           cfg_data
);

    logic [aphm_pkg::HOLD_W-1:0] hold_samples_reg;
    logic [aphm_pkg::FALL_W-1:0] fall_factor_reg;
    aphm_pkg::cfg_t              cfg;

    logic           front_push;
    aphm_pkg::cmd_t front_cmd;
    logic           cmd_full;
    logic           cmd_pop;
    logic           cmd_empty;
    aphm_pkg::cmd_t cmd_head;

    assign cfg_ready        = 1'b1;
    assign cfg.hold_samples = hold_samples_reg;
    assign cfg.fall_factor  = fall_factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_samples_reg <= aphm_pkg::HOLD_RESET;
            fall_factor_reg  <= aphm_pkg::FALL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                aphm_pkg::REG_HOLD_SAMPLES:
                begin
                    hold_samples_reg <= cfg_data[aphm_pkg::HOLD_W-1:0];
                end
                aphm_pkg::REG_FALL_FACTOR:
                begin
                    fall_factor_reg <= cfg_data[aphm_pkg::FALL_W-1:0];
                end
                default:
                begin
                    hold_samples_reg <= hold_samples_reg;
                end
            endcase
        end
    end

    aphm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cmd_push (front_push),
        .cmd      (front_cmd),
        .cmd_full (cmd_full)
    );

    aphm_cmd_fifo u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_head),
        .empty     (cmd_empty)
    );

    aphm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// File: test/audio_peak_hold_meter_core_checker.sv
`timescale 1ns / 100ps

module audio_peak_hold_meter_core_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  aphm_pkg::in_item_t             item,
    input  logic                           pop,
    input  logic                           empty,
    input  aphm_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [aphm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aphm_pkg::CFG_W-1:0]     cfg_data,
    output int                             errors,
    output int                             outstanding
);

    logic [aphm_pkg::HOLD_W-1:0]  hold_samples;
    logic [aphm_pkg::FALL_W-1:0]  fall_factor;

    logic [aphm_pkg::LEVEL_W-1:0] period_max;
    logic [aphm_pkg::COUNT_W-1:0] period_count;
    logic [aphm_pkg::LEVEL_W-1:0] held_max;
    logic [aphm_pkg::LEVEL_W-1:0] peak_value;
    logic [aphm_pkg::HOLD_W-1:0]  hold_left;
    logic                         restart_armed;

    aphm_pkg::out_item_t          pending_readings[$];
    int                           mismatches;

    always @(posedge clk or negedge rst_n)
    begin
        aphm_pkg::out_item_t                            want;
        logic [aphm_pkg::LEVEL_W-1:0]                   mag;
        logic [aphm_pkg::LEVEL_W-1:0]                   m;
        logic [aphm_pkg::LEVEL_W+aphm_pkg::FALL_W-1:0]  product;

        if (!rst_n)
        begin
            hold_samples  = aphm_pkg::HOLD_RESET;
            fall_factor   = aphm_pkg::FALL_RESET;
            period_max    = '0;
            period_count  = '0;
            held_max      = '0;
            peak_value    = '0;
            hold_left     = '0;
            restart_armed = 1'b0;
            pending_readings.delete();
            mismatches    = 0;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result transaction
            if (pop && !empty)
            begin
                if (pending_readings.size() == 0)
                begin
                    $error("result with no expectation: max_level %0d peak_level %0d",
                           result.max_level, result.peak_level);
                    mismatches++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (result.max_level !== want.max_level)
                    begin
                        $error("max_level: expected %0d, actual %0d",
                               want.max_level, result.max_level);
                        mismatches++;
                    end
                    if (result.peak_level !== want.peak_level)
                    begin
                        $error("peak_level: expected %0d, actual %0d",
                               want.peak_level, result.peak_level);
                        mismatches++;
                    end
                end
            end

            // input transaction
            if (push && !full)
            begin
                if (item.action == aphm_pkg::ACT_READ)
                begin
                    want.max_level  = held_max;
                    want.peak_level = peak_value;
                    pending_readings.push_back(want);
                    restart_armed = 1'b1;
                end
                else
                begin
                    // most negative sample maps to 2^(N-1), still fits unsigned
                    mag = item.sample[aphm_pkg::LEVEL_W-1] ? -item.sample : item.sample;
                    if (mag > period_max)
                        period_max = mag;
                    if (period_count < aphm_pkg::COUNT_W'(aphm_pkg::MAX_PERIOD))
                        period_count = period_count + 1'b1;

                    if (item.last_of_period)
                    begin
                        m = period_max;
                        if (restart_armed)
                        begin
                            held_max      = m;
                            restart_armed = 1'b0;
                        end
                        else if (m > held_max)
                            held_max = m;

                        if (m >= peak_value)
                        begin
                            peak_value = m;
                            hold_left  = hold_samples;
                        end
                        else if (hold_left != '0)
                            hold_left = (hold_left > aphm_pkg::HOLD_W'(period_count))
                                      ? hold_left - aphm_pkg::HOLD_W'(period_count) : '0;
                        else
                        begin
                            product    = peak_value * fall_factor;
                            peak_value = product[aphm_pkg::LEVEL_W+aphm_pkg::FALL_W-1:
                                                 aphm_pkg::FALL_W];
                        end
                        period_max   = '0;
                        period_count = '0;
                    end
                end
            end

            // configuration transaction
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == aphm_pkg::REG_HOLD_SAMPLES)
                    hold_samples = cfg_data[aphm_pkg::HOLD_W-1:0];
                else if (cfg_index == aphm_pkg::REG_FALL_FACTOR)
                    fall_factor = cfg_data[aphm_pkg::FALL_W-1:0];
            end

            errors      <= mismatches;
            outstanding <= pending_readings.size();
        end
    end

endmodule

// File: test/audio_peak_hold_meter_core_tb.sv
`timescale 1ns / 100ps

module audio_peak_hold_meter_core_tb;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            push      = 1'b0;
    aphm_pkg::in_item_t              in_item   = '0;
    logic                            full;
    logic                            empty;
    logic                            pop       = 1'b0;
    aphm_pkg::out_item_t             meter_out;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [aphm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [aphm_pkg::CFG_W-1:0]      cfg_data  = '0;

    int                    errors;
    int                    outstanding;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;

    always #5 clk = ~clk;

    audio_peak_hold_meter_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (in_item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (meter_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    audio_peak_hold_meter_core_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (in_item),
        .pop         (pop),
        .empty       (empty),
        .result      (meter_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_stall_pct);

    function automatic aphm_pkg::in_item_t sample_item(
        logic signed [aphm_pkg::SAMPLE_BITS-1:0] s, logic last);
        aphm_pkg::in_item_t it;
        it.action         = aphm_pkg::ACT_SAMPLE;
        it.sample         = s;
        it.last_of_period = last;
        return it;
    endfunction

    // sample and last_of_period are don't-care on a read; randomize them
    function automatic aphm_pkg::in_item_t read_item();
        aphm_pkg::in_item_t it;
        it.action         = aphm_pkg::ACT_READ;
        it.sample         = aphm_pkg::SAMPLE_BITS'($urandom);
        it.last_of_period = 1'($urandom_range(1));
        return it;
    endfunction

    // push stays high across back-to-back transactions
    task automatic push_item(aphm_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [aphm_pkg::CFG_IDX_W-1:0] idx,
                             logic [aphm_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait out every expected reading plus the pipeline tail
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int                                      len;
        int                                      sel;
        int                                      sent;
        logic [aphm_pkg::SAMPLE_BITS-1:0]        mag;
        logic signed [aphm_pkg::SAMPLE_BITS-1:0] s;
        logic [aphm_pkg::CFG_W-1:0]              hold_val;
        logic [aphm_pkg::CFG_W-1:0]              fall_val;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        push_item(read_item());
        push_item(sample_item(24'sh7FFFFF, 1'b1));
        push_item(read_item());
        push_item(sample_item(-24'sd8388608, 1'b0));
        push_item(sample_item(24'sd0, 1'b1));
        push_item(read_item());
        push_item(sample_item(24'sd1, 1'b0));
        push_item(sample_item(-24'sd1, 1'b1));
        push_item(read_item());
        push_item(read_item());
        push_item(sample_item(24'sd0, 1'b1));
        push_item(read_item());
        push_item(sample_item(-24'sd5, 1'b1));
        push_item(sample_item(24'sd3, 1'b1));
        push_item(read_item());
        // read in the middle of an open period
        push_item(sample_item(24'sh7FFFFF, 1'b0));
        push_item(read_item());
        push_item(sample_item(24'sd2, 1'b1));
        push_item(read_item());
        settle();

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            case (phase)
                0: begin
                    hold_val = aphm_pkg::CFG_W'(0);
                    fall_val = aphm_pkg::CFG_W'(65535);
                end
                1: begin
                    hold_val = aphm_pkg::CFG_W'(5);
                    fall_val = aphm_pkg::CFG_W'(0);
                end
                2: begin
                    hold_val = aphm_pkg::CFG_W'(16777215);
                    fall_val = aphm_pkg::CFG_W'(40000);
                end
                3: begin
                    hold_val = aphm_pkg::CFG_W'(3);
                    fall_val = aphm_pkg::CFG_W'(32768);
                end
                4: begin
                    hold_val = aphm_pkg::CFG_W'($urandom_range(0, 40));
                    fall_val = aphm_pkg::CFG_W'($urandom);
                end
                5: begin
                    hold_val = aphm_pkg::CFG_W'(72000);
                    fall_val = aphm_pkg::CFG_W'(65335);
                end
                default: begin
                    hold_val = aphm_pkg::CFG_W'(1);
                    fall_val = aphm_pkg::CFG_W'($urandom);
                end
            endcase
            write_reg(aphm_pkg::REG_HOLD_SAMPLES, hold_val);
            write_reg(aphm_pkg::REG_FALL_FACTOR, fall_val);

            sent = 0;
            while (sent < 150)
            begin
                if ($urandom_range(99) < 35)
                begin
                    push_item(read_item());
                    sent++;
                end
                else
                begin
                    // mostly short periods, now and then a long one
                    len = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                    begin
                        sel = $urandom_range(99);
                        if (sel < 55)
                            mag = aphm_pkg::SAMPLE_BITS'($urandom_range(0, 255));
                        else if (sel < 80)
                            mag = aphm_pkg::SAMPLE_BITS'($urandom_range(0, 65535));
                        if (sel < 80)
                            s = $urandom_range(1) ? -$signed(mag) : $signed(mag);
                        else if (sel < 92)
                            s = aphm_pkg::SAMPLE_BITS'($urandom);
                        else
                            case ($urandom_range(3))
                                0: s = 24'sh7FFFFF;
                                1: s = -24'sd8388608;
                                2: s = 24'sd0;
                                default: s = -24'sd1;
                            endcase
                        push_item(sample_item(s, i == len - 1));
                    end
                    sent += len;
                end
            end
            settle();
        end

        if (errors == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/aphm_pkg.sv
sv/aphm_front.sv
sv/aphm_cmd_fifo.sv
sv/aphm_back.sv
sv/audio_peak_hold_meter_core.sv
test/audio_peak_hold_meter_core_checker.sv
test/audio_peak_hold_meter_core_tb.sv
